// ===== hdl/mcrf_pkg.sv =====
// ---------------------------------------------------------------------------
// mcrf_pkg
// Shared constants, types and codes for the multi-channel ring FIFO.
// ---------------------------------------------------------------------------
package mcrf_pkg;

  // Queue geometry
  localparam int CHANNELS  = 8;
  localparam int DEPTH     = 1024;

  // Fixed field widths
  localparam int CMD_W     = 1;
  localparam int CHAN_W    = 3;
  localparam int WORD_W    = 64;
  localparam int LEN_W     = 16;
  localparam int ENTRY_W   = WORD_W + LEN_W;

  // Derived widths
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int STORE_D   = CHANNELS * DEPTH;
  localparam int ADDR_W    = (STORE_D > 1) ? $clog2(STORE_D) : 1;

  typedef logic [CH_IDX_W-1:0] ch_idx_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  // Operation codes
  localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
  localparam logic [CMD_W-1:0] CMD_PULL = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture the input beat
    logic exec;     // check pointers, write or issue read, update pointers
    logic capture;  // take read data into the result register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_pull;
    logic ok;
  } dp_status_t;

  // Step a pointer round the ring
  function automatic ptr_t ptr_advance(input ptr_t p);
    ptr_advance = (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

// ===== hdl/mcrf_ram.sv =====
// ---------------------------------------------------------------------------
// mcrf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module mcrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== hdl/mcrf_ctrl.sv =====
// ---------------------------------------------------------------------------
// mcrf_ctrl
// Sequencer for one operation at a time: accept, execute, read, present.
// ---------------------------------------------------------------------------
module mcrf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  mcrf_pkg::dp_status_t status,
  output mcrf_pkg::ctl_cmd_t   cmd
);

  mcrf_pkg::state_t state_r;
  mcrf_pkg::state_t state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcrf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decide next state and drive the datapath
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    unique case (state_r)
      mcrf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = mcrf_pkg::ST_EXEC;
        end
      end
      mcrf_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.is_pull && status.ok) begin
          state_nxt = mcrf_pkg::ST_READ;
        end else begin
          state_nxt = mcrf_pkg::ST_OUT;
        end
      end
      mcrf_pkg::ST_READ: begin
        cmd.capture = 1'b1;
        state_nxt   = mcrf_pkg::ST_OUT;
      end
      mcrf_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = mcrf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mcrf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/mcrf_dp.sv =====
// ---------------------------------------------------------------------------
// mcrf_dp
// Datapath: per-channel pointers, the entry store and the result register.
// ---------------------------------------------------------------------------
module mcrf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mcrf_pkg::ctl_cmd_t                cmd,
  output mcrf_pkg::dp_status_t              status,
  input  logic [mcrf_pkg::CMD_W-1:0]        in_command,
  input  logic [mcrf_pkg::CHAN_W-1:0]       in_channel,
  input  logic [mcrf_pkg::WORD_W-1:0]       in_payload_word,
  input  logic [mcrf_pkg::LEN_W-1:0]        in_payload_length,
  output logic                              out_success,
  output logic [mcrf_pkg::WORD_W-1:0]       out_pulled_word,
  output logic [mcrf_pkg::LEN_W-1:0]        out_pulled_length
);

  // Captured input beat
  logic [mcrf_pkg::CMD_W-1:0]  command_r;
  logic [mcrf_pkg::CHAN_W-1:0] channel_r;
  logic [mcrf_pkg::WORD_W-1:0] word_r;
  logic [mcrf_pkg::LEN_W-1:0]  length_r;

  // Pointers
  mcrf_pkg::ptr_t wr_ptr_r [mcrf_pkg::CHANNELS];
  mcrf_pkg::ptr_t rd_ptr_r [mcrf_pkg::CHANNELS];

  // Result register
  logic                        success_r;
  logic [mcrf_pkg::WORD_W-1:0] pword_r;
  logic [mcrf_pkg::LEN_W-1:0]  plen_r;

  mcrf_pkg::ch_idx_t ch_idx;
  logic              ch_ok;
  mcrf_pkg::ptr_t    wp;
  mcrf_pkg::ptr_t    rp;
  mcrf_pkg::ptr_t    wp_adv;
  mcrf_pkg::ptr_t    rp_adv;
  logic              is_pull;
  logic              push_ok;
  logic              pull_ok;
  mcrf_pkg::addr_t   base;
  mcrf_pkg::addr_t   waddr;
  mcrf_pkg::addr_t   raddr;
  logic              ram_we;
  logic              ram_re;
  logic [mcrf_pkg::ENTRY_W-1:0] ram_rdata;

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command_r <= in_command;
      channel_r <= in_channel;
      word_r    <= in_payload_word;
      length_r  <= in_payload_length;
    end
  end

  // Look up the addressed queue and test full and empty
  always_comb begin
    ch_idx  = mcrf_pkg::ch_idx_t'(channel_r);
    ch_ok   = (int'(channel_r) < mcrf_pkg::CHANNELS);
    wp      = wr_ptr_r[ch_idx];
    rp      = rd_ptr_r[ch_idx];
    wp_adv  = mcrf_pkg::ptr_advance(wp);
    rp_adv  = mcrf_pkg::ptr_advance(rp);
    is_pull = (command_r == mcrf_pkg::CMD_PULL);
    push_ok = ch_ok && !is_pull && (wp_adv != rp);
    pull_ok = ch_ok && is_pull && (wp != rp);
    base    = mcrf_pkg::addr_t'(int'(ch_idx) * mcrf_pkg::DEPTH);
    waddr   = base + mcrf_pkg::addr_t'(wp);
    raddr   = base + mcrf_pkg::addr_t'(rp);
    ram_we  = cmd.exec && push_ok;
    ram_re  = cmd.exec && pull_ok;
  end

  assign status.is_pull = is_pull;
  assign status.ok      = push_ok || pull_ok;

  // Advance the pointers on a successful operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mcrf_pkg::CHANNELS; i++) begin
        wr_ptr_r[i] <= '0;
        rd_ptr_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (push_ok) begin
        wr_ptr_r[ch_idx] <= wp_adv;
      end
      if (pull_ok) begin
        rd_ptr_r[ch_idx] <= rp_adv;
      end
    end
  end

  // Entry store, word in the upper bits and length in the lower
  mcrf_ram #(
    .WIDTH (mcrf_pkg::ENTRY_W),
    .DEPTH (mcrf_pkg::STORE_D)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (waddr),
    .wdata   ({word_r, length_r}),
    .re      (ram_re),
    .raddr   (raddr),
    .rdata_r (ram_rdata)
  );

  // Build the result: status first, data once the read returns
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      success_r <= push_ok || pull_ok;
      pword_r   <= '0;
      plen_r    <= '0;
    end else if (cmd.capture) begin
      pword_r   <= ram_rdata[mcrf_pkg::ENTRY_W-1:mcrf_pkg::LEN_W];
      plen_r    <= ram_rdata[mcrf_pkg::LEN_W-1:0];
    end
  end

  assign out_success       = success_r;
  assign out_pulled_word   = pword_r;
  assign out_pulled_length = plen_r;

endmodule

// ===== hdl/multi_channel_ring_fifo.sv =====
// ---------------------------------------------------------------------------
// multi_channel_ring_fifo
// Eight independent ring queues sharing one entry store, push and pull.
// ---------------------------------------------------------------------------
// One operation is handled at a time. A push or any failed operation goes
// from the accepted input beat through the execute step to the result beat;
// a successful pull adds the registered read of the shared entry store.
// A new input beat is taken once the previous result beat has been delivered.
// Each queue holds DEPTH-1 entries; a push to a full queue or a pull from
// an empty one returns success low and zero data. The store needs no
// initialisation after reset: only written slots are read.
module multi_channel_ring_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mcrf_pkg::CMD_W-1:0]        in_command,
  input  logic [mcrf_pkg::CHAN_W-1:0]       in_channel,
  input  logic [mcrf_pkg::WORD_W-1:0]       in_payload_word,
  input  logic [mcrf_pkg::LEN_W-1:0]        in_payload_length,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_success,
  output logic [mcrf_pkg::WORD_W-1:0]       out_pulled_word,
  output logic [mcrf_pkg::LEN_W-1:0]        out_pulled_length
);

  mcrf_pkg::ctl_cmd_t   cmd;
  mcrf_pkg::dp_status_t status;

  // Sequencer
  mcrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Pointers, store and result register
  mcrf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_command        (in_command),
    .in_channel        (in_channel),
    .in_payload_word   (in_payload_word),
    .in_payload_length (in_payload_length),
    .out_success       (out_success),
    .out_pulled_word   (out_pulled_word),
    .out_pulled_length (out_pulled_length)
  );

endmodule
